[sv/ehc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ehc_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFF_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MIN_FRAME_W     = 12;

    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IPV4_VL_PLAIN  = 8'h45;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_IGMP     = 8'd2;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
    localparam logic [7:0]  ICMP_CODE_NONE = 8'd0;

    localparam logic [MIN_FRAME_W-1:0] RST_MIN_FRAME = 12'd42;
    localparam logic [15:0] RST_HTTP_PORT     = 16'd80;
    localparam logic [15:0] RST_FTP_CTRL_PORT = 16'd21;
    localparam logic [15:0] RST_FTP_DATA_PORT = 16'd20;
    localparam logic [15:0] RST_SSH_PORT      = 16'd22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FRAME     = 3'd0,
        CFG_HTTP_PORT     = 3'd1,
        CFG_FTP_CTRL_PORT = 3'd2,
        CFG_FTP_DATA_PORT = 3'd3,
        CFG_SSH_PORT      = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        CLASS_SHORT     = 4'd0,
        CLASS_ARP       = 4'd1,
        CLASS_TCP       = 4'd2,
        CLASS_UDP       = 4'd3,
        CLASS_ICMP      = 4'd4,
        CLASS_IGMP      = 4'd5,
        CLASS_OTHER_IP  = 4'd6,
        CLASS_IP_NOT_45 = 4'd7,
        CLASS_OTHER_ETH = 4'd8
    } frame_class_t;

    typedef enum logic [2:0] {
        APP_NONE       = 3'd0,
        APP_HTTP       = 3'd1,
        APP_FTP_CTRL   = 3'd2,
        APP_FTP_DATA   = 3'd3,
        APP_SSH        = 3'd4,
        APP_ECHO_REQ   = 3'd5,
        APP_ECHO_REP   = 3'd6,
        APP_OTHER_ICMP = 3'd7
    } app_kind_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [2:0]  app_kind;
        logic [7:0]  ip_protocol;
        logic [7:0]  type_byte;
        logic [7:0]  code_byte;
        logic [31:0] group_ip;
    } out_t;

    typedef struct packed {
        logic [OFF_W-1:0] len;
        logic [47:0]      dest_mac;
        logic [47:0]      source_mac;
        logic [15:0]      ethertype;
        logic [7:0]       version_length;
        logic [7:0]       protocol;
        logic [31:0]      source_addr;
        logic [31:0]      dest_addr;
        logic [63:0]      l4_word;
    } rec_t;

    typedef struct packed {
        logic [MIN_FRAME_W-1:0] min_frame_bytes;
        logic [15:0]            http_port;
        logic [15:0]            ftp_control_port;
        logic [15:0]            ftp_data_port;
        logic [15:0]            ssh_port;
    } cfg_t;

endpackage

`default_nettype wire

[sv/ethernet_ip_header_classifier.sv]
// ethernet / ipv4 header classifier
// s_ channel: one frame byte per request, s_data.last_byte marks the end of a frame.
// m_ channel: one request per frame, the class, captured header fields and
//   application kind of that frame.
// cfg_ port: plain write of the frame length threshold and the four tcp ports;
//   the user must write only while no frame is in flight; the block does not enforce it.
// throughput: one byte per cycle while s_ready is high, set by the front capture
//   stage; a one-byte frame can follow another, so with m_ready high up to one
//   result per cycle. a frame's header is queued with its last byte and is
//   classified into the output register when popped, once that register is free.
// a two-entry queue of captured headers separates the byte capture from the
//   classifying back end; when the receiver stalls the output register holds,
//   the queue fills and s_ready drops once both queue entries hold headers.
// reset clears the byte offset, all captured fields, the queue and m_valid,
//   and loads the default threshold and ports.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_ip_header_classifier
    import ehc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire in_t                   s_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output out_t                       m_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    rec_t front_rec;
    rec_t q_rec;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic in_fire;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_frame_bytes  <= RST_MIN_FRAME;
            cfg_reg.http_port        <= RST_HTTP_PORT;
            cfg_reg.ftp_control_port <= RST_FTP_CTRL_PORT;
            cfg_reg.ftp_data_port    <= RST_FTP_DATA_PORT;
            cfg_reg.ssh_port         <= RST_SSH_PORT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_FRAME:     cfg_reg.min_frame_bytes  <= cfg_wdata[MIN_FRAME_W-1:0];
                CFG_HTTP_PORT:     cfg_reg.http_port        <= cfg_wdata;
                CFG_FTP_CTRL_PORT: cfg_reg.ftp_control_port <= cfg_wdata;
                CFG_FTP_DATA_PORT: cfg_reg.ftp_data_port    <= cfg_wdata;
                CFG_SSH_PORT:      cfg_reg.ssh_port         <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ehc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .in_fire (in_fire),
        .rec     (front_rec),
        .push    (push)
    );

    ehc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_data  (front_rec),
        .wr_en    (push),
        .full     (q_full),
        .rd_data  (q_rec),
        .rd_valid (q_valid),
        .rd_en    (q_pop)
    );

    ehc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec       (q_rec),
        .rec_valid (q_valid),
        .rec_pop   (q_pop),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

`default_nettype wire

[sv/ehc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ehc_front
    import ehc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  in_data,
    input  wire logic in_fire,
    output rec_t      rec,
    output logic      push
);

    rec_t             cap_reg;
    rec_t             cap_next;
    logic [OFF_W-1:0] off;
    logic             arp;
    logic [7:0]       b;

    assign off = cap_reg.len;
    assign b   = in_data.frame_byte;
    assign arp = (cap_reg.ethertype == ETHERTYPE_ARP);

    always_comb begin
        cap_next = cap_reg;
        if (off < OFF_W'(MAX_FRAME_BYTES)) begin
            cap_next.len = off + OFF_W'(1);
            if (off < OFF_W'(6)) begin
                cap_next.dest_mac = {cap_reg.dest_mac[39:0], b};
            end else if (off < OFF_W'(12)) begin
                cap_next.source_mac = {cap_reg.source_mac[39:0], b};
            end else if (off < OFF_W'(14)) begin
                cap_next.ethertype = {cap_reg.ethertype[7:0], b};
            end else if (off == OFF_W'(14)) begin
                cap_next.version_length = b;
            end else if (off == OFF_W'(23)) begin
                cap_next.protocol = b;
            end
            if (arp) begin
                if (off >= OFF_W'(28) && off < OFF_W'(32)) begin
                    cap_next.source_addr = {cap_reg.source_addr[23:0], b};
                end
                if (off >= OFF_W'(38) && off < OFF_W'(42)) begin
                    cap_next.dest_addr = {cap_reg.dest_addr[23:0], b};
                end
            end else begin
                if (off >= OFF_W'(26) && off < OFF_W'(30)) begin
                    cap_next.source_addr = {cap_reg.source_addr[23:0], b};
                end
                if (off >= OFF_W'(30) && off < OFF_W'(34)) begin
                    cap_next.dest_addr = {cap_reg.dest_addr[23:0], b};
                end
            end
            if (off >= OFF_W'(34) && off < OFF_W'(42)) begin
                cap_next.l4_word = {cap_reg.l4_word[55:0], b};
            end
        end
    end

    assign rec  = cap_next;
    assign push = in_fire && in_data.last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (in_fire) begin
            if (in_data.last_byte) begin
                cap_reg <= '0;
            end else begin
                cap_reg <= cap_next;
            end
        end
    end

endmodule

`default_nettype wire

[sv/ehc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ehc_queue
    import ehc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire rec_t wr_data,
    input  wire logic wr_en,
    output logic      full,
    output rec_t      rd_data,
    output logic      rd_valid,
    input  wire logic rd_en
);

    rec_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/ehc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ehc_back
    import ehc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire rec_t rec,
    input  wire logic rec_valid,
    output logic      rec_pop,
    output out_t      m_data,
    output logic      m_valid,
    input  wire logic m_ready
);

    out_t        res;
    out_t        data_reg;
    logic        valid_reg;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  t;
    logic [7:0]  c;

    assign sp = rec.l4_word[63:48];
    assign dp = rec.l4_word[47:32];
    assign t  = rec.l4_word[63:56];
    assign c  = rec.l4_word[55:48];

    always_comb begin
        res            = '0;
        res.dest_mac   = rec.dest_mac;
        res.source_mac = rec.source_mac;
        if (rec.len < cfg.min_frame_bytes) begin
            res.frame_class = CLASS_SHORT;
        end else if (rec.ethertype == ETHERTYPE_ARP) begin
            res.frame_class = CLASS_ARP;
            res.source_ip   = rec.source_addr;
            res.dest_ip     = rec.dest_addr;
        end else if (rec.ethertype == ETHERTYPE_IPV4) begin
            if (rec.version_length != IPV4_VL_PLAIN) begin
                res.frame_class = CLASS_IP_NOT_45;
            end else begin
                res.source_ip   = rec.source_addr;
                res.dest_ip     = rec.dest_addr;
                res.ip_protocol = rec.protocol;
                case (rec.protocol)
                    PROTO_TCP: begin
                        res.frame_class = CLASS_TCP;
                        res.source_port = sp;
                        res.dest_port   = dp;
                        if (sp == cfg.http_port || dp == cfg.http_port) begin
                            res.app_kind = APP_HTTP;
                        end else if (sp == cfg.ftp_control_port
                                     || dp == cfg.ftp_control_port) begin
                            res.app_kind = APP_FTP_CTRL;
                        end else if (sp == cfg.ftp_data_port || dp == cfg.ftp_data_port) begin
                            res.app_kind = APP_FTP_DATA;
                        end else if (sp == cfg.ssh_port || dp == cfg.ssh_port) begin
                            res.app_kind = APP_SSH;
                        end
                    end
                    PROTO_UDP: begin
                        res.frame_class = CLASS_UDP;
                        res.source_port = sp;
                        res.dest_port   = dp;
                    end
                    PROTO_ICMP: begin
                        res.frame_class = CLASS_ICMP;
                        res.type_byte   = t;
                        res.code_byte   = c;
                        if (t == ICMP_ECHO_REQ && c == ICMP_CODE_NONE) begin
                            res.app_kind = APP_ECHO_REQ;
                        end else if (t == ICMP_ECHO_REP && c == ICMP_CODE_NONE) begin
                            res.app_kind = APP_ECHO_REP;
                        end else begin
                            res.app_kind = APP_OTHER_ICMP;
                        end
                    end
                    PROTO_IGMP: begin
                        res.frame_class = CLASS_IGMP;
                        res.type_byte   = t;
                        res.group_ip    = rec.l4_word[31:0];
                    end
                    default: begin
                        res.frame_class = CLASS_OTHER_IP;
                    end
                endcase
            end
        end else begin
            res.frame_class = CLASS_OTHER_ETH;
        end
    end

    assign rec_pop = rec_valid && (!valid_reg || m_ready);
    assign m_data  = data_reg;
    assign m_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
